// ===== rtl/ctfr_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN transport frame reassembler - shared types and constants
// Frame types, status codes and the job record passed from the
// classifier to the result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctfr_pkg;

   // Protocol control information codes
   localparam logic [7:0] PCI_FIRST  = 8'h10;
   localparam logic [7:0] SEQ_FIRST  = 8'h21;
   localparam logic [7:0] SEQ_LIMIT  = 8'h30;
   localparam logic [7:0] NEG_RESP   = 8'h7F;

   // Data bytes per CAN frame
   localparam int         FRAME_BYTES = 8;
   localparam logic [3:0] DLC_MAX     = 4'd8;

   // Job queue between classifier and serializer
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      ST_SINGLE_DONE = 3'd0,
      ST_FIRST_START = 3'd1,
      ST_APPENDED    = 3'd2,
      ST_MULTI_DONE  = 3'd3,
      ST_IGNORED     = 3'd4,
      ST_SEQ_ERROR   = 3'd5,
      ST_INVALID     = 3'd6
   } status_type;

   // One received frame
   typedef struct packed {
      logic [28:0]                 can_id;
      logic [3:0]                  dlc;
      logic [FRAME_BYTES-1:0][7:0] data;    // data[0] is the PCI byte
   } frame_type;

   // Work for the serializer: emit data[first_idx + k] for k < byte_cnt
   typedef struct packed {
      status_type                  status;
      logic [28:0]                 src_id;
      logic [7:0]                  service_id;
      logic                        multi_frame;
      logic [FRAME_BYTES-1:0][7:0] data;
      logic                        first_idx;
      logic [3:0]                  byte_cnt;
      logic [6:0]                  pos0;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

endpackage

`default_nettype wire

// ===== rtl/ctfr_queue.sv =====
// ----------------------------------------------------------------------------
// CAN transport frame reassembler - job queue
// Short FIFO of classified frames between the classifier and the
// serializer so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfr_queue
   import ctfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output qstat_type    qstat
);

   job_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job    = entry_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.valid = (count_ff != '0);

endmodule

`default_nettype wire

// ===== rtl/ctfr_front.sv =====
// ----------------------------------------------------------------------------
// CAN transport frame reassembler - frame classifier
// Accepts a frame, decodes its PCI byte, updates the collection state
// and pushes one job describing the results into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfr_front
   import ctfr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_tvalid,
   output logic           req_tready,
   input  wire frame_type frame,
   input  wire qstat_type qstat,
   output logic           push,
   output job_type        push_job
);

   logic        seq_open_ff,  seq_open_in;
   logic [7:0]  exp_len_ff,   exp_len_in;
   logic [7:0]  next_seq_ff,  next_seq_in;
   logic [6:0]  collected_ff, collected_in;
   logic [7:0]  service_ff,   service_in;

   logic [3:0]  dlc_sat;
   logic [3:0]  added;
   logic [6:0]  total;
   logic [7:0]  pci;

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && req_tready;

   // Saturate the length and count the bytes after the PCI byte
   assign dlc_sat = (frame.dlc > DLC_MAX) ? DLC_MAX : frame.dlc;
   assign added   = (dlc_sat > 4'd1) ? (dlc_sat - 4'd1) : 4'd0;
   assign total   = collected_ff + {3'b000, added};
   assign pci     = frame.data[0];

   // Classify the frame and work out the next state
   always_comb begin
      seq_open_in  = seq_open_ff;
      exp_len_in   = exp_len_ff;
      next_seq_in  = next_seq_ff;
      collected_in = collected_ff;
      service_in   = service_ff;

      push_job.status      = ST_INVALID;
      push_job.multi_frame = 1'b0;
      push_job.first_idx   = 1'b1;
      push_job.byte_cnt    = 4'd0;
      push_job.pos0        = 7'd0;

      if (pci < PCI_FIRST) begin
         // Single frame: take the service, drop any open collection
         service_in           = (frame.data[1] == NEG_RESP) ? frame.data[2] : frame.data[1];
         seq_open_in          = 1'b0;
         exp_len_in           = 8'd0;
         next_seq_in          = SEQ_FIRST;
         collected_in         = 7'd0;
         push_job.status      = ST_SINGLE_DONE;
         push_job.first_idx   = 1'b0;
         push_job.byte_cnt    = dlc_sat;
      end else if (pci == PCI_FIRST) begin
         // First frame: open a new collection
         exp_len_in           = frame.data[1];
         service_in           = frame.data[2];
         next_seq_in          = SEQ_FIRST;
         seq_open_in          = 1'b1;
         collected_in         = {3'b000, added};
         push_job.status      = ST_FIRST_START;
         push_job.multi_frame = 1'b1;
         push_job.byte_cnt    = added;
      end else if (pci inside {[SEQ_FIRST:SEQ_LIMIT - 8'd1]}) begin
         if (!seq_open_ff) begin
            push_job.status = ST_IGNORED;
         end else if (pci != next_seq_ff) begin
            push_job.status      = ST_SEQ_ERROR;
            push_job.multi_frame = 1'b1;
         end else begin
            // Matching consecutive frame: append its bytes
            push_job.multi_frame = 1'b1;
            push_job.byte_cnt    = added;
            push_job.pos0        = collected_ff;
            next_seq_in          = next_seq_ff + 8'd1;
            if ({1'b0, total} >= exp_len_ff) begin
               push_job.status = ST_MULTI_DONE;
               seq_open_in     = 1'b0;
               exp_len_in      = 8'd0;
               next_seq_in     = SEQ_FIRST;
               collected_in    = 7'd0;
            end else begin
               push_job.status = ST_APPENDED;
               collected_in    = total;
            end
         end
      end

      push_job.src_id     = frame.can_id;
      push_job.service_id = service_in;
      push_job.data       = frame.data;
   end

   // Hold collection state, update on accepted requests only
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_open_ff  <= 1'b0;
         exp_len_ff   <= 8'd0;
         next_seq_ff  <= SEQ_FIRST;
         collected_ff <= 7'd0;
         service_ff   <= 8'd0;
      end else if (push) begin
         seq_open_ff  <= seq_open_in;
         exp_len_ff   <= exp_len_in;
         next_seq_ff  <= next_seq_in;
         collected_ff <= collected_in;
         service_ff   <= service_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ctfr_back.sv =====
// ----------------------------------------------------------------------------
// CAN transport frame reassembler - result serializer
// Walks the head job into the output register one byte per cycle while the
// register is free, and pops the job as its last result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfr_back
   import ctfr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire qstat_type qstat,
   input  wire job_type   head_job,
   output logic           pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output status_type     rsp_status,
   output logic [28:0]    rsp_src_id,
   output logic [7:0]     rsp_service_id,
   output logic           rsp_multi_frame,
   output logic           rsp_byte_valid,
   output logic [7:0]     rsp_byte_value,
   output logic [6:0]     rsp_byte_position,
   output logic           rsp_tlast
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff;
   status_type  status_ff;
   logic [28:0] src_id_ff;
   logic [7:0]  service_ff;
   logic        multi_ff;
   logic        bvalid_ff;
   logic [7:0]  bvalue_ff;
   logic [6:0]  bpos_ff;
   logic        last_ff;

   logic        out_free;
   logic        load;
   logic        has_bytes;
   logic        is_last;
   logic [2:0]  byte_sel;

   assign out_free  = !valid_ff || rsp_tready;
   assign load      = qstat.valid && out_free;
   assign has_bytes = (head_job.byte_cnt != 4'd0);
   assign is_last   = !has_bytes || (({1'b0, idx_ff} + 4'd1) == head_job.byte_cnt);
   assign pop       = load && is_last;
   assign byte_sel  = {2'b00, head_job.first_idx} + idx_ff;

   // Step through the bytes of the head job
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= head_job.status;
         src_id_ff   <= head_job.src_id;
         service_ff  <= head_job.service_id;
         multi_ff    <= head_job.multi_frame;
         bvalid_ff   <= has_bytes;
         bvalue_ff   <= has_bytes ? head_job.data[byte_sel] : 8'd0;
         bpos_ff     <= has_bytes ? head_job.pos0 + {4'd0, idx_ff} : 7'd0;
         last_ff     <= is_last;
      end
   end

   assign rsp_tvalid        = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_src_id        = src_id_ff;
   assign rsp_service_id    = service_ff;
   assign rsp_multi_frame   = multi_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_byte_value    = bvalue_ff;
   assign rsp_byte_position = bpos_ff;
   assign rsp_tlast         = last_ff;

   // A result without a byte closes its frame and carries zeros
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !bvalid_ff) |-> (last_ff && bpos_ff == 7'd0 && bvalue_ff == 8'd0))
      else $error("byte-less result not a clean final result");

   // Byte index stays inside the head job
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (qstat.valid && has_bytes) |-> ({1'b0, idx_ff} < head_job.byte_cnt))
      else $error("serializer index past job byte count");

   // Mid-job the index is nonzero only while the job is still queued
   a_idx_clear: assert property (@(posedge clock) disable iff (reset)
      !qstat.valid |-> (idx_ff == 3'd0))
      else $error("serializer index left over without a job");

   // Popping a job always completes a load
   a_pop_load: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job popped without a final result");

endmodule

`default_nettype wire

// ===== rtl/can_transport_frame_reassembler.sv =====
// ----------------------------------------------------------------------------
// CAN transport frame reassembler - top level
// Receive-side reassembly of segmented CAN transport messages.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one CAN frame per transfer. The block
//   classifies it (single, first, consecutive or invalid), tracks the
//   service identifier and the collection state, and streams on the
//   response channel one result per message byte the frame adds, or one
//   byte-less status result when it adds none. rsp_tlast marks the final
//   result of each frame.
//   An accepted frame is written into the job queue, and its first result
//   is then loaded from the queue head into the output register.
//   Throughput: results leave one per cycle while the receiver takes them,
//   and a frame yields max(1, bytes added) results, at most 8; the rate is
//   set by the single output register. A two-entry job queue lets the
//   classifier take the next frame while results still drain.
//   Reset clears the collection state, the queue and the output valid flag.
//   When the receiver stalls, the output holds, the queue fills and
//   req_tready falls; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module can_transport_frame_reassembler
   import ctfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Request: can_id[28:0], dlc[32:29], pci_byte[40:33], byte1[48:41],
   //          byte2[56:49], byte3[64:57], byte4[72:65], byte5[80:73],
   //          byte6[88:81], byte7[96:89], zero fill [103:97]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [103:0] req_tdata,
   // Response: src_id[28:0], service_id[36:29], byte_value[44:37],
   //           byte_position[51:45], zero fill [55:52]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [55:0]       rsp_tdata,
   // Response user: status[2:0], multi_frame[3], byte_valid[4]
   output logic [4:0]        rsp_tuser,
   output logic              rsp_tlast
);

   frame_type   frame;
   qstat_type   qstat;
   job_type     push_job;
   job_type     head_job;
   logic        push;
   logic        pop;
   status_type  status;
   logic [28:0] src_id;
   logic [7:0]  service_id;
   logic        multi_frame;
   logic        byte_valid;
   logic [7:0]  byte_value;
   logic [6:0]  byte_position;

   // Unpack the request
   assign frame.can_id  = req_tdata[28:0];
   assign frame.dlc     = req_tdata[32:29];
   assign frame.data[0] = req_tdata[40:33];
   assign frame.data[1] = req_tdata[48:41];
   assign frame.data[2] = req_tdata[56:49];
   assign frame.data[3] = req_tdata[64:57];
   assign frame.data[4] = req_tdata[72:65];
   assign frame.data[5] = req_tdata[80:73];
   assign frame.data[6] = req_tdata[88:81];
   assign frame.data[7] = req_tdata[96:89];

   ctfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .frame      (frame),
      .qstat      (qstat),
      .push       (push),
      .push_job   (push_job)
   );

   ctfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   ctfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .head_job          (head_job),
      .pop               (pop),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_status        (status),
      .rsp_src_id        (src_id),
      .rsp_service_id    (service_id),
      .rsp_multi_frame   (multi_frame),
      .rsp_byte_valid    (byte_valid),
      .rsp_byte_value    (byte_value),
      .rsp_byte_position (byte_position),
      .rsp_tlast         (rsp_tlast)
   );

   // Pack the response
   assign rsp_tdata = {4'b0000, byte_position, byte_value, service_id, src_id};
   assign rsp_tuser = {byte_valid, multi_frame, status};

endmodule

`default_nettype wire

// ===== verif/can_transport_frame_reassembler_tb.sv =====
// ----------------------------------------------------------------------------
// CAN transport frame reassembler - testbench
// Streams CAN frames into the block: a directed list, then random
// multi-frame messages with noise, aborts and sequence errors mixed in.
// Expected results are predicted from the accepted frames and compared
// field by field with every result, under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module can_transport_frame_reassembler_tb;
   import ctfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PRINT_LIMIT = 40;
   localparam int FRAME_TARGET = 100;

   // One CAN frame; data[0] is the PCI byte
   typedef struct packed {
      logic [28:0]     can_id;
      logic [3:0]      dlc;
      logic [7:0][7:0] data;
   } can_frame_type;

   // One predicted byte result
   typedef struct {
      status_type  status;
      logic [28:0] src_id;
      logic [7:0]  service_id;
      logic        multi_frame;
      logic        byte_valid;
      logic [7:0]  byte_value;
      logic [6:0]  byte_position;
      logic        last;
   } byte_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic [4:0]   rsp_tuser;
   logic         rsp_tlast;

   // Reassembly state mirrored from the block
   logic       asm_open = 1'b0;
   logic [7:0] asm_length = '0;
   logic [7:0] asm_next_seq = SEQ_FIRST;
   logic [6:0] asm_count = '0;
   logic [7:0] asm_service = '0;

   can_frame_type   frame_q[$];
   byte_result_type byte_stream_q[$];
   can_frame_type   frame_in_flight;
   int              frames_total = 0;
   int              frames_accepted = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_gap = 0;
   int              send_calm = 0;
   int              recv_hold = 0;
   int              recv_calm = 0;

   can_transport_frame_reassembler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void close_message();
      asm_open = 1'b0;
      asm_length = '0;
      asm_next_seq = SEQ_FIRST;
      asm_count = '0;
   endfunction

   // Queue data[first..count-1] at positions pos0 onward, or one byte-less result
   function automatic void queue_bytes(can_frame_type f, int first, int count, int pos0,
                                       status_type st, logic multi);
      int              n;
      byte_result_type r;
      n = (count > first) ? count - first : 0;
      r.status = st;
      r.src_id = f.can_id;
      r.service_id = asm_service;
      r.multi_frame = multi;
      if (n == 0) begin
         r.byte_valid = 1'b0;
         r.byte_value = '0;
         r.byte_position = '0;
         r.last = 1'b1;
         byte_stream_q.insert(byte_stream_q.size(), r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.byte_valid = 1'b1;
            r.byte_value = f.data[first + k];
            r.byte_position = 7'(pos0 + k);
            r.last = (k == n - 1);
            byte_stream_q.insert(byte_stream_q.size(), r);
         end
      end
   endfunction

   // Classify one accepted frame and advance the message state
   function automatic void reassemble(can_frame_type f);
      int         eff;
      int         added;
      int         pos0;
      int         total;
      logic [7:0] pci;
      eff = (f.dlc > DLC_MAX) ? DLC_MAX : f.dlc;
      added = (eff > 1) ? eff - 1 : 0;
      pci = f.data[0];
      if (pci < PCI_FIRST) begin
         asm_service = (f.data[1] == NEG_RESP) ? f.data[2] : f.data[1];
         close_message();
         queue_bytes(f, 0, eff, 0, ST_SINGLE_DONE, 1'b0);
      end else if (pci == PCI_FIRST) begin
         asm_length = f.data[1];
         asm_service = f.data[2];
         asm_next_seq = SEQ_FIRST;
         asm_open = 1'b1;
         queue_bytes(f, 1, eff, 0, ST_FIRST_START, 1'b1);
         asm_count = 7'(added);
      end else if (pci >= SEQ_FIRST && pci < SEQ_LIMIT) begin
         if (!asm_open) begin
            queue_bytes(f, 0, 0, 0, ST_IGNORED, 1'b0);
         end else if (pci != asm_next_seq) begin
            queue_bytes(f, 0, 0, 0, ST_SEQ_ERROR, 1'b1);
         end else begin
            pos0 = asm_count;
            total = (pos0 + added) & 127;
            asm_next_seq = asm_next_seq + 8'd1;
            if (total >= asm_length) begin
               close_message();
               queue_bytes(f, 1, eff, pos0, ST_MULTI_DONE, 1'b1);
            end else begin
               asm_count = 7'(total);
               queue_bytes(f, 1, eff, pos0, ST_APPENDED, 1'b1);
            end
         end
      end else begin
         queue_bytes(f, 0, 0, 0, ST_INVALID, 1'b0);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result();
      byte_result_type want;
      if (byte_stream_q.size() == 0) begin
         report_mismatch("result with none pending", rsp_tdata[31:0], 0);
         return;
      end
      want = byte_stream_q.pop_front();
      if (rsp_tuser[2:0] != want.status)
         report_mismatch("status", rsp_tuser[2:0], want.status);
      if (rsp_tdata[28:0] != want.src_id)
         report_mismatch("src_id", rsp_tdata[28:0], want.src_id);
      if (rsp_tdata[36:29] != want.service_id)
         report_mismatch("service_id", rsp_tdata[36:29], want.service_id);
      if (rsp_tuser[3] != want.multi_frame)
         report_mismatch("multi_frame", rsp_tuser[3], want.multi_frame);
      if (rsp_tuser[4] != want.byte_valid)
         report_mismatch("byte_valid", rsp_tuser[4], want.byte_valid);
      if (rsp_tdata[44:37] != want.byte_value)
         report_mismatch("byte_value", rsp_tdata[44:37], want.byte_value);
      if (rsp_tdata[51:45] != want.byte_position)
         report_mismatch("byte_position", rsp_tdata[51:45], want.byte_position);
      if (rsp_tlast != want.last)
         report_mismatch("last_of_run", rsp_tlast, want.last);
   endtask

   // Mostly short gaps, a few long ones
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: present queued frames, predict on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            reassemble(frame_in_flight);
            frames_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (frame_q.size() > 0) begin
               frame_in_flight = frame_q.pop_front();
               req_tdata <= {7'd0, frame_in_flight.data, frame_in_flight.dlc,
                             frame_in_flight.can_id};
               req_tvalid <= 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
               end else begin
                  send_gap = draw_gap();
                  if ($urandom_range(0, 39) == 0)
                     send_calm = $urandom_range(15, 40);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: check each accepted result, stall at random
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (recv_hold == 0) begin
            if (recv_calm > 0)
               recv_calm--;
            else if ($urandom_range(0, 3) == 0)
               recv_hold = draw_gap();
            else if ($urandom_range(0, 60) == 0)
               recv_calm = $urandom_range(15, 40);
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic can_frame_type make_frame(logic [28:0] id, logic [3:0] dlc,
                                                logic [7:0] pci, logic [7:0] b1,
                                                logic [7:0] b2);
      can_frame_type f;
      f.can_id = id;
      f.dlc = dlc;
      for (int i = 3; i < 8; i++)
         f.data[i] = 8'($urandom_range(0, 255));
      f.data[0] = pci;
      f.data[1] = b1;
      f.data[2] = b2;
      return f;
   endfunction

   // Append one frame to the pending list
   function automatic void enqueue_frame(can_frame_type f);
      frame_q.insert(frame_q.size(), f);
   endfunction

   function automatic logic [28:0] rand_id();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return 29'($urandom());
   endfunction

   function automatic logic [3:0] rand_dlc();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 4'd8;
      if (r < 9) return 4'($urandom_range(0, 8));
      return 4'($urandom_range(9, 15));
   endfunction

   function automatic int rand_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 0;
      if (r < 85) return $urandom_range(1, 40);
      if (r < 95) return $urandom_range(41, 127);
      return $urandom_range(128, 255);
   endfunction

   task automatic push_single();
      logic [7:0] b1;
      b1 = ($urandom_range(0, 3) == 0) ? NEG_RESP : 8'($urandom_range(0, 255));
      enqueue_frame(make_frame(rand_id(), rand_dlc(), 8'($urandom_range(0, 15)),
                               b1, 8'($urandom_range(0, 255))));
   endtask

   // Any byte-0 value; mostly invalid, ignored or out-of-order frames
   task automatic push_noise();
      enqueue_frame(make_frame(rand_id(), 4'($urandom_range(0, 15)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255))));
   endtask

   // First frame and its consecutive frames, with optional disturbances
   task automatic push_message(int len, bit clean);
      can_frame_type f;
      int            count;
      int            seq;
      int            eff;
      int            r;
      bit            done;
      f = make_frame(rand_id(), rand_dlc(), PCI_FIRST, 8'(len), 8'($urandom_range(0, 255)));
      enqueue_frame(f);
      eff = (f.dlc > DLC_MAX) ? DLC_MAX : f.dlc;
      count = (eff > 1) ? eff - 1 : 0;
      seq = SEQ_FIRST;
      done = 1'b0;
      while (!done) begin
         r = clean ? 99 : $urandom_range(0, 99);
         if (r < 6) begin
            // out-of-order sequence number
            enqueue_frame(make_frame(rand_id(), rand_dlc(),
                                     8'(SEQ_FIRST + (seq - SEQ_FIRST
                                        + $urandom_range(1, 14)) % 15),
                                     8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255))));
         end else if (r < 9) begin
            // single frame aborts the message
            push_single();
            done = 1'b1;
         end else if (r < 12) begin
            push_noise();
         end else if (seq < SEQ_LIMIT) begin
            f = make_frame(rand_id(), rand_dlc(), 8'(seq), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            enqueue_frame(f);
            eff = (f.dlc > DLC_MAX) ? DLC_MAX : f.dlc;
            count = (count + ((eff > 1) ? eff - 1 : 0)) & 127;
            seq++;
            if (count >= len)
               done = 1'b1;
         end else begin
            // sequence numbers used up: nothing matches any more
            enqueue_frame(make_frame(rand_id(), rand_dlc(),
                                     8'($urandom_range(SEQ_FIRST, SEQ_LIMIT - 1)),
                                     8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255))));
            done = 1'b1;
         end
      end
   endtask

   initial begin
      can_frame_type f;
      int            r;

      // Single frames at the field extremes, negative response, short dlc
      f = make_frame('0, 4'd0, 8'h00, 8'h00, 8'h00);
      f.data = '0;
      enqueue_frame(f);
      f = make_frame('1, 4'd15, 8'h0F, 8'hFF, 8'hFF);
      f.data = '1;
      enqueue_frame(f);
      enqueue_frame(make_frame(29'h0ABCDEF, 4'd8, 8'h03, NEG_RESP, 8'h55));
      enqueue_frame(make_frame(29'h1555_5555, 4'd1, 8'h01, 8'h22, 8'h33));
      // Consecutive frame with no message open, invalid types
      enqueue_frame(make_frame(29'h123, 4'd8, SEQ_FIRST, 8'h11, 8'h22));
      enqueue_frame(make_frame(29'h124, 4'd8, 8'h20, 8'h11, 8'h22));
      enqueue_frame(make_frame(29'h125, 4'd8, 8'hFF, 8'hFF, 8'hFF));
      // Message of 20 bytes: sequence error, empty append, completion
      enqueue_frame(make_frame(29'h200, 4'd8, PCI_FIRST, 8'd20, 8'h22));
      enqueue_frame(make_frame(29'h201, 4'd8, 8'h22, 8'h01, 8'h02));
      enqueue_frame(make_frame(29'h202, 4'd8, 8'h21, 8'h03, 8'h04));
      enqueue_frame(make_frame(29'h203, 4'd1, 8'h22, 8'h05, 8'h06));
      enqueue_frame(make_frame(29'h204, 4'd8, 8'h23, 8'h07, 8'h08));
      // Zero-length message closed by an empty consecutive frame
      enqueue_frame(make_frame(29'h300, 4'd0, PCI_FIRST, 8'd0, 8'h31));
      enqueue_frame(make_frame(29'h301, 4'd0, SEQ_FIRST, 8'h00, 8'h00));
      // Single frame aborts an open message
      enqueue_frame(make_frame(29'h400, 4'd8, PCI_FIRST, 8'd30, 8'h19));
      enqueue_frame(make_frame(29'h401, 4'd3, 8'h02, 8'h3E, 8'h00));
      enqueue_frame(make_frame(29'h402, 4'd8, SEQ_FIRST, 8'h00, 8'h00));
      // First frame with no data, invalid frame inside the message
      enqueue_frame(make_frame(29'h500, 4'd1, PCI_FIRST, 8'd5, 8'h27));
      enqueue_frame(make_frame(29'h501, 4'd8, SEQ_LIMIT, 8'h00, 8'h00));
      enqueue_frame(make_frame(29'h502, 4'd8, SEQ_FIRST, 8'hA5, 8'h5A));
      enqueue_frame(make_frame(29'h503, 4'd8, 8'h11, 8'h00, 8'h00));
      enqueue_frame(make_frame(29'h504, 4'd8, 8'h2F, 8'h00, 8'h00));

      // Long message that runs out of sequence numbers
      push_message(255, 1'b1);
      // Fill up with random traffic to the frame target
      while (frame_q.size() < FRAME_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 65)
            push_message(rand_length(), 1'b0);
         else if (r < 85)
            push_single();
         else
            push_noise();
      end
      frames_total = frame_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every frame and every result, then let the pipeline settle
      while (frames_accepted < frames_total || byte_stream_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
